// File: rtl/core/lru_pr_pkg.sv
// Shared constants, register codes and result type for the LRU page replacement block.
package lru_pr_pkg;

    // Build-time sizes
    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;
    localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W     = SLOT_W;

    // Fixed field widths
    localparam int CFG_W        = 4;
    localparam int FRAME_SLOT_W = 3;
    localparam int FAULT_W      = 32;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_ACTIVE_FRAMES = 1'b0;
    localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = CFG_W'(3);

    // One result item
    typedef struct packed {
        logic                    hit;
        logic [FRAME_SLOT_W-1:0] frame_slot;
        logic                    evicted_valid;
        logic [PAGE_BITS-1:0]    evicted_page;
        logic [FAULT_W-1:0]      fault_count;
    } t_result;

endpackage

// File: rtl/core/lru_pr_cfg.sv
// Configuration register file (APB-style) holding the active frame count.
module lru_pr_cfg
    import lru_pr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [CFG_W-1:0]  o_active_frames
);

    logic [CFG_W-1:0] r_active_frames;
    logic             wr_en;
    logic [0:0]       reg_idx;

    assign reg_idx = paddr[2:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_ACTIVE_FRAMES);

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_frames <= ACTIVE_FRAMES_RST;
        end else if (wr_en) begin
            r_active_frames <= pwdata[CFG_W-1:0];
        end
    end

    // Read back; unmapped address reads zero
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_ACTIVE_FRAMES) begin
            prdata = DATA_W'(r_active_frames);
        end
    end

    assign o_active_frames = r_active_frames;

endmodule

// File: rtl/core/lru_pr_core.sv
// Frame table, recency ranks and fault counter with the single-pass lookup/update logic.
module lru_pr_core
    import lru_pr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CFG_W-1:0]     i_active_frames,
    input  logic                 i_adv,
    input  logic [PAGE_BITS-1:0] i_page,
    output t_result              o_result
);

    logic [PAGE_BITS-1:0] r_pages [MAX_FRAMES];
    logic [RANK_W-1:0]    r_rank  [MAX_FRAMES];
    logic [RANK_W-1:0]    n_rank  [MAX_FRAMES];
    logic [CNT_W-1:0]     r_filled, n_filled;
    logic [FAULT_W-1:0]   r_fault, n_fault;

    logic [CNT_W-1:0]  n_use, limit, old_rank;
    logic              hit, fill;
    logic [SLOT_W-1:0] hit_slot, victim, slot;
    logic [RANK_W-1:0] best_rank;

    // Clamp the configured frame count to 1..MAX_FRAMES
    always_comb begin
        if (i_active_frames == '0) begin
            n_use = CNT_W'(1);
        end else if (CNT_W'(i_active_frames) > CNT_W'(MAX_FRAMES)
                     || i_active_frames > CFG_W'(MAX_FRAMES)) begin
            n_use = CNT_W'(MAX_FRAMES);
        end else begin
            n_use = CNT_W'(i_active_frames);
        end
        limit = (r_filled < n_use) ? r_filled : n_use;
    end

    // Parallel tag compare, lowest matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (CNT_W'(i) < limit && r_pages[i] == i_page) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    // Oldest slot among those in use
    always_comb begin
        victim    = '0;
        best_rank = r_rank[0];
        for (int i = 1; i < MAX_FRAMES; i++) begin
            if (CNT_W'(i) < n_use && r_rank[i] > best_rank) begin
                victim    = SLOT_W'(i);
                best_rank = r_rank[i];
            end
        end
    end

    // Slot choice and recency update
    always_comb begin
        fill     = !hit && (r_filled < n_use);
        n_filled = fill ? r_filled + CNT_W'(1) : r_filled;
        if (hit) begin
            slot     = hit_slot;
            old_rank = CNT_W'(r_rank[hit_slot]);
        end else if (fill) begin
            slot     = SLOT_W'(r_filled);
            old_rank = n_filled;
        end else begin
            slot     = victim;
            old_rank = CNT_W'(best_rank);
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_rank[i] = r_rank[i];
            if (SLOT_W'(i) == slot) begin
                n_rank[i] = '0;
            end else if (CNT_W'(i) < n_filled && CNT_W'(r_rank[i]) < old_rank) begin
                n_rank[i] = r_rank[i] + RANK_W'(1);
            end
        end
        n_fault = r_fault;
        if (!hit && r_fault != '1) begin
            n_fault = r_fault + FAULT_W'(1);
        end
    end

    // Result for the item now in the input register
    always_comb begin
        o_result.hit           = hit;
        o_result.frame_slot    = FRAME_SLOT_W'(slot);
        o_result.evicted_valid = !hit && !fill;
        o_result.evicted_page  = (!hit && !fill) ? r_pages[victim] : '0;
        o_result.fault_count   = n_fault;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_fault  <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_adv) begin
            r_filled <= n_filled;
            r_fault  <= n_fault;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Frame table: written on a miss when the item advances, no reset
    always_ff @(posedge i_clk) begin
        if (i_adv && !hit) begin
            r_pages[slot] <= i_page;
        end
    end

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(MAX_FRAMES))
        else $error("filled frame count above maximum");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> !o_result.evicted_valid)
        else $error("eviction reported on a hit");

    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !hit) |=> (r_fault == $past(r_fault) + FAULT_W'(1)
                             || r_fault == '1))
        else $error("fault count did not advance on a miss");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && fill) |=> (r_filled == $past(r_filled) + CNT_W'(1)))
        else $error("filled count did not advance on a fill");

endmodule

// File: rtl/core/lru_page_replacement_top.sv
// Each item passes through the input register and then the result register before its result is taken.
// Throughput: one item per cycle while results are taken; the lookup and rank update of the frame table
// finish in the cycle an item moves from the input register to the result register.
// A result item that is not taken holds the input register, so o_in_ready drops once it is full.
// Reset (synchronous, active low): no frames filled, ranks and fault count zero,
// active_frames back to 3; frame contents are left as they were.
module lru_page_replacement_top
    import lru_pr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [PAGE_BITS-1:0]    i_page_number,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic [FRAME_SLOT_W-1:0] o_frame_slot,
    output logic                    o_evicted_valid,
    output logic [PAGE_BITS-1:0]    o_evicted_page,
    output logic [FAULT_W-1:0]      o_fault_count
);

    logic [CFG_W-1:0]     active_frames;
    logic                 r_in_vld;
    logic [PAGE_BITS-1:0] r_in_page;
    logic                 r_out_vld;
    t_result              r_out;
    t_result              result;
    logic                 adv;

    lru_pr_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_active_frames(active_frames)
    );

    lru_pr_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_active_frames(active_frames),
        .i_adv          (adv),
        .i_page         (r_in_page),
        .o_result       (result)
    );

    // Item moves on when the result register is free or being emptied
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    // Input and result valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_page <= i_page_number;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_hit           = r_out.hit;
    assign o_frame_slot    = r_out.frame_slot;
    assign o_evicted_valid = r_out.evicted_valid;
    assign o_evicted_page  = r_out.evicted_page;
    assign o_fault_count   = r_out.fault_count;

endmodule

// File: verif/tb_lru_page_replacement_top.sv
// Self-checking testbench for the LRU page replacement block: directed and random page traffic.
module tb_lru_page_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lru_pr_pkg::*;

    localparam logic [ADDR_W-1:0] FRAMES_ADDR   = ADDR_W'(4 * int'(REG_ACTIVE_FRAMES));
    // first address past the register list; writes there must do nothing
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);
    localparam int                POOL_SIZE     = 12;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [PAGE_BITS-1:0]    i_page_number;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_hit;
    logic [FRAME_SLOT_W-1:0] o_frame_slot;
    logic                    o_evicted_valid;
    logic [PAGE_BITS-1:0]    o_evicted_page;
    logic [FAULT_W-1:0]      o_fault_count;

    // Shadow copy of the frame table
    logic [PAGE_BITS-1:0] shadow_pages [MAX_FRAMES];
    int                   rank_of      [MAX_FRAMES];
    int                   fill_cnt    = 0;
    logic [FAULT_W-1:0]   fault_tally = '0;
    logic [CFG_W-1:0]     cfg_frames  = ACTIVE_FRAMES_RST;

    t_result expected_results[$];
    int      err_cnt     = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;

    lru_page_replacement_top dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver backpressure
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic int effective_frames();
        if (cfg_frames == 0)
            return 1;
        if (cfg_frames > MAX_FRAMES)
            return MAX_FRAMES;
        return int'(cfg_frames);
    endfunction

    // Slot s becomes most recent; slots younger than its old rank age by one
    function automatic void promote(int s, int old_rank);
        for (int i = 0; i < fill_cnt && i < MAX_FRAMES; i++) begin
            if (i != s && rank_of[i] < old_rank)
                rank_of[i]++;
        end
        rank_of[s] = 0;
    endfunction

    // Apply one page access to the shadow table and return the expected item
    function automatic t_result resolve_access(logic [PAGE_BITS-1:0] pg);
        t_result res;
        int      n;
        int      lim;
        int      slot;
        int      best;
        bit      found;
        n     = effective_frames();
        lim   = (fill_cnt < n) ? fill_cnt : n;
        slot  = 0;
        found = 1'b0;
        res   = '0;
        for (int i = 0; i < lim; i++) begin
            if (!found && shadow_pages[i] == pg) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            promote(slot, rank_of[slot]);
        end else begin
            if (fill_cnt < n) begin
                slot = fill_cnt;
                shadow_pages[slot] = pg;
                fill_cnt++;
                promote(slot, fill_cnt);
            end else begin
                best = 0;
                for (int i = 1; i < n; i++) begin
                    if (rank_of[i] > rank_of[best])
                        best = i;
                end
                slot = best;
                res.evicted_valid = 1'b1;
                res.evicted_page  = shadow_pages[slot];
                shadow_pages[slot] = pg;
                promote(slot, rank_of[slot]);
            end
            if (fault_tally != '1)
                fault_tally++;
        end
        res.hit         = found;
        res.frame_slot  = FRAME_SLOT_W'(slot);
        res.fault_count = fault_tally;
        return res;
    endfunction

    // Send one page item; called at a rising edge
    task automatic send_page(input logic [PAGE_BITS-1:0] pg);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= pg;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(resolve_access(pg));
    endtask

    // Hold off the sender until every outstanding item has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup then access phase
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == FRAMES_ADDR)
            cfg_frames = data[CFG_W-1:0];
    endtask

    // Compare each returned item with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: slot %0d", o_frame_slot);
                err_cnt++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_hit !== exp_res.hit) begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, o_hit);
                    err_cnt++;
                end
                if (o_frame_slot !== exp_res.frame_slot) begin
                    $error("frame_slot: expected %0d, got %0d", exp_res.frame_slot,
                           o_frame_slot);
                    err_cnt++;
                end
                if (o_evicted_valid !== exp_res.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d", exp_res.evicted_valid,
                           o_evicted_valid);
                    err_cnt++;
                end
                if (o_evicted_page !== exp_res.evicted_page) begin
                    $error("evicted_page: expected %h, got %h", exp_res.evicted_page,
                           o_evicted_page);
                    err_cnt++;
                end
                if (o_fault_count !== exp_res.fault_count) begin
                    $error("fault_count: expected %0d, got %0d", exp_res.fault_count,
                           o_fault_count);
                    err_cnt++;
                end
            end
        end
    end

    // Fill, hit, LRU eviction, out-of-range counts and a count lowered while full and raised again
    task automatic test_directed_cases();
        tx_idle_pct = 9;
        rx_idle_pct = 61;
        // reset default of three frames
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h0000);
        send_page(16'hABCD);
        send_page(16'hFFFF);
        wait_idle();
        // zero frames behaves as one
        write_reg(FRAMES_ADDR, 32'h0000_0000);
        send_page(16'hABCD);
        send_page(16'hABCD);
        wait_idle();
        // above the maximum behaves as the maximum
        write_reg(FRAMES_ADDR, 32'h0000_000F);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0001);
        send_page(16'h8000);
        send_page(16'h7FFF);
        send_page(16'hFFFF);
        send_page(16'h4242);
        wait_idle();
        // shrink while all frames hold pages: upper slots drop out of the search
        write_reg(FRAMES_ADDR, 32'h0000_0002);
        send_page(16'h8000);
        send_page(16'h0F0F);
        wait_idle();
        // grow back: stored upper pages hit again
        write_reg(FRAMES_ADDR, 32'h0000_0008);
        send_page(16'h7FFF);
        send_page(16'hAAAA);
        send_page(16'h9999);
        wait_idle();
        // only the low nibble counts
        write_reg(FRAMES_ADDR, 32'hFFFF_FFF1);
        send_page(16'h0000);
        send_page(16'h0000);
        wait_idle();
    endtask

    // A write past the register list leaves the frame count alone
    task automatic test_unmapped_register();
        write_reg(UNMAPPED_ADDR, 32'h0000_0005);
        send_page(16'h3C3C);
        send_page(16'h0000);
        wait_idle();
    endtask

    // Random pages drawn mostly from a working set a little larger than the frames
    task automatic run_chunk(input int count, input logic [CFG_W-1:0] frames);
        logic [PAGE_BITS-1:0] pool [POOL_SIZE];
        logic [DATA_W-1:0]    wdata;
        int                   wsize;
        wdata = $urandom();
        wdata[CFG_W-1:0] = frames;
        write_reg(FRAMES_ADDR, wdata);
        foreach (pool[k])
            pool[k] = PAGE_BITS'($urandom());
        wsize = effective_frames() + 2;
        if (wsize > POOL_SIZE)
            wsize = POOL_SIZE;
        repeat (count) begin
            if ($urandom_range(99) < 80)
                send_page(pool[$urandom_range(wsize - 1)]);
            else
                send_page(PAGE_BITS'($urandom()));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        run_chunk(150, CFG_W'(MAX_FRAMES));
        run_chunk(150, CFG_W'(1));
        run_chunk(150, CFG_W'($urandom_range(15)));
        run_chunk(150, CFG_W'($urandom_range(15)));
    endtask

    // Test sequence
    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_page_number <= '0;
        foreach (rank_of[k])
            rank_of[k] = 0;
        foreach (shadow_pages[k])
            shadow_pages[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_unmapped_register();
        test_random_traffic(9, 61);
        test_random_traffic(61, 9);
        test_random_traffic(0, 0);

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lru_pr_pkg.sv
rtl/core/lru_pr_cfg.sv
rtl/core/lru_pr_core.sv
rtl/core/lru_page_replacement_top.sv
verif/tb_lru_page_replacement_top.sv
